### hdl/tcce_pkg.sv
package tcce_pkg;

  // Result command codes
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Control bytes and printable range
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_FORM_FEED = 8'd12;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] PRINT_HI     = 8'h7E;

  // Field widths
  localparam int CHAR_W     = 8;
  localparam int FG_W       = 4;
  localparam int BG_W       = 3;
  localparam int POS_W      = 11;
  localparam int WORD_W     = BG_W + FG_W + CHAR_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR = 8'd1;
  localparam logic [FG_W-1:0]      TEXT_COLOUR_RST = 4'hF;
  localparam logic [BG_W-1:0]      BACK_COLOUR_RST = 3'h0;

  // Decoded action for one character
  typedef struct packed {
    cmd_t command;
    logic scroll;
  } step_ctl_t;

endpackage

### hdl/tcce_cursor.sv
module tcce_cursor #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8,
  localparam int COL_W    = $clog2(COLUMNS),
  localparam int ROW_W    = $clog2(ROWS)
) (
  input  logic [tcce_pkg::CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]            row,
  input  logic [COL_W-1:0]            col,
  output logic [ROW_W-1:0]            next_row,
  output logic [COL_W-1:0]            next_col,
  output tcce_pkg::step_ctl_t         ctl
);

  logic [COL_W-1:0] tab_stop [COLUMNS];
  logic             at_bottom;
  logic             at_eol;

  // Build the tab stop table, clamped to the last column
  for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
    localparam int Stop = (g / TAB_WIDTH + 1) * TAB_WIDTH;
    assign tab_stop[g] = COL_W'((Stop >= COLUMNS) ? (COLUMNS - 1) : Stop);
  end

  assign at_bottom = (row == ROW_W'(ROWS - 1));
  assign at_eol    = (col == COL_W'(COLUMNS - 1));

  // Decode the byte and move the cursor
  always_comb begin
    next_row    = row;
    next_col    = col;
    ctl.command = tcce_pkg::CMD_NONE;
    ctl.scroll  = 1'b0;
    unique case (char_code)
      tcce_pkg::CH_BACKSPACE: begin
        if (col != '0) next_col = col - 1'b1;
      end
      tcce_pkg::CH_TAB: begin
        next_col = tab_stop[col];
      end
      tcce_pkg::CH_NEWLINE: begin
        next_col = '0;
        if (at_bottom) ctl.command = tcce_pkg::CMD_SCROLL;
        else next_row = row + 1'b1;
      end
      tcce_pkg::CH_FORM_FEED: begin
        ctl.command = tcce_pkg::CMD_CLEAR;
        next_row    = '0;
        next_col    = '0;
      end
      tcce_pkg::CH_RETURN: begin
        next_col = '0;
      end
      default: begin
        if (char_code >= tcce_pkg::PRINT_LO && char_code <= tcce_pkg::PRINT_HI) begin
          ctl.command = tcce_pkg::CMD_WRITE;
          if (at_eol) begin
            next_col = '0;
            if (at_bottom) ctl.scroll = 1'b1;
            else next_row = row + 1'b1;
          end else begin
            next_col = col + 1'b1;
          end
        end
      end
    endcase
  end

endmodule

### hdl/text_console_cursor_engine_top.sv
// Throughput: one word per cycle while out_ready is high. A printable byte that
// wraps off the bottom row gives two results (write, then scroll) and holds the
// input until the scroll is taken. Results are held in the output registers.
// The cursor update is a single combinational pass from the cursor registers.
// Reset (rst_n low, synchronous) homes the cursor, sets colours to 15 on 0 and
// empties the output register.
module text_console_cursor_engine_top #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcce_pkg::CHAR_W-1:0]     in_char_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tcce_pkg::cmd_t                  out_command,
  output logic [tcce_pkg::POS_W-1:0]      out_cell_address,
  output logic [tcce_pkg::WORD_W-1:0]     out_cell_word,
  output logic [tcce_pkg::POS_W-1:0]      out_cursor_position,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  logic [ROW_W-1:0]              cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]              cursor_col_r, cursor_col_nxt;
  logic [tcce_pkg::FG_W-1:0]     text_colour_r;
  logic [tcce_pkg::BG_W-1:0]     back_colour_r;
  tcce_pkg::step_ctl_t           ctl;
  logic                          in_fire, out_fire, is_write;
  logic [tcce_pkg::POS_W-1:0]    cell_addr, cursor_pos;

  logic                          out_valid_r;
  tcce_pkg::cmd_t                out_command_r;
  logic [tcce_pkg::POS_W-1:0]    out_cell_address_r;
  logic [tcce_pkg::WORD_W-1:0]   out_cell_word_r;
  logic [tcce_pkg::POS_W-1:0]    out_cursor_position_r;
  logic                          out_last_r;

  tcce_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_cursor (
    .char_code (in_char_code),
    .row       (cursor_row_r),
    .col       (cursor_col_r),
    .next_row  (cursor_row_nxt),
    .next_col  (cursor_col_nxt),
    .ctl       (ctl)
  );

  // Take a new word when the output register is empty or its final result is taken
  assign in_ready  = !out_valid_r || (out_ready && out_last_r);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  assign is_write   = (ctl.command == tcce_pkg::CMD_WRITE);
  assign cell_addr  = tcce_pkg::POS_W'(cursor_row_r * COLUMNS)
                    + tcce_pkg::POS_W'(cursor_col_r);
  assign cursor_pos = tcce_pkg::POS_W'(cursor_row_nxt * COLUMNS)
                    + tcce_pkg::POS_W'(cursor_col_nxt);

  // Colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_colour_r <= tcce_pkg::TEXT_COLOUR_RST;
      back_colour_r <= tcce_pkg::BACK_COLOUR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tcce_pkg::REG_TEXT_COLOUR) text_colour_r <= cfg_data;
      else if (cfg_index == tcce_pkg::REG_BACK_COLOUR)
        back_colour_r <= cfg_data[tcce_pkg::BG_W-1:0];
    end
  end

  // Cursor registers advance on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_row_r <= '0;
      cursor_col_r <= '0;
    end else if (in_fire) begin
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
    end
  end

  // Output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
      out_last_r  <= !ctl.scroll;
    end else if (out_fire) begin
      out_valid_r <= !out_last_r;
      out_last_r  <= 1'b1;
    end
  end

  // Output payload: load a new result, or swap in the trailing scroll
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_command_r         <= ctl.command;
      out_cell_address_r    <= is_write ? cell_addr : '0;
      out_cell_word_r       <= is_write ? {back_colour_r, text_colour_r, in_char_code} : '0;
      out_cursor_position_r <= cursor_pos;
    end else if (out_fire && !out_last_r) begin
      out_command_r      <= tcce_pkg::CMD_SCROLL;
      out_cell_address_r <= '0;
      out_cell_word_r    <= '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command         = out_command_r;
  assign out_cell_address    = out_cell_address_r;
  assign out_cell_word       = out_cell_word_r;
  assign out_cursor_position = out_cursor_position_r;
  assign out_last            = out_last_r;

  // Checks
  a_pair_starts_with_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_command_r == tcce_pkg::CMD_WRITE)
    else $error("non-final result is not a cell write");

  a_scroll_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last_r |=> out_valid_r && out_last_r &&
      out_command_r == tcce_pkg::CMD_SCROLL && $stable(out_cursor_position_r))
    else $error("scroll did not follow the wrapped write");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_col_r < COLUMNS) && (cursor_row_r < ROWS))
    else $error("cursor left the screen");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_command_r != tcce_pkg::CMD_WRITE |->
      out_cell_address_r == '0 && out_cell_word_r == '0)
    else $error("cell fields set on a non-write result");

endmodule

### dv/text_console_cursor_engine_check.sv
module text_console_cursor_engine_check #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [tcce_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  tcce_pkg::cmd_t                  out_command,
  input  logic [tcce_pkg::POS_W-1:0]      out_cell_address,
  input  logic [tcce_pkg::WORD_W-1:0]     out_cell_word,
  input  logic [tcce_pkg::POS_W-1:0]      out_cursor_position,
  input  logic                            out_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // One screen operation as it leaves the block
  typedef struct packed {
    tcce_pkg::cmd_t              command;
    logic [tcce_pkg::POS_W-1:0]  address;
    logic [tcce_pkg::WORD_W-1:0] word;
    logic [tcce_pkg::POS_W-1:0]  cursor;
    logic                        last;
  } screen_op_t;

  logic [tcce_pkg::FG_W-1:0] fg_colour;
  logic [tcce_pkg::BG_W-1:0] bg_colour;
  logic [4:0]                row;
  logic [6:0]                col;
  screen_op_t                ops_due[$];

  // Step to the next row; report when the screen has to scroll
  function automatic logic move_down();
    if (int'(row) + 1 >= ROWS) begin
      row = 5'(ROWS - 1);
      return 1'b1;
    end
    row = row + 5'd1;
    return 1'b0;
  endfunction

  // Update the cursor for one byte and queue the operations it causes
  task automatic predict_char(input logic [tcce_pkg::CHAR_W-1:0] ch);
    tcce_pkg::cmd_t cmd;
    int             addr;
    int             glyph_word;
    int             target;
    int             curs;
    logic           wrap_scroll;
    screen_op_t     op;
    cmd         = tcce_pkg::CMD_NONE;
    addr        = 0;
    glyph_word  = 0;
    wrap_scroll = 1'b0;
    if (ch == tcce_pkg::CH_BACKSPACE) begin
      if (col != '0) col = col - 7'd1;
    end else if (ch == tcce_pkg::CH_TAB) begin
      // a column already on a stop still moves to the next one
      target = (int'(col) / TAB_WIDTH + 1) * TAB_WIDTH;
      col = 7'((target >= COLUMNS) ? COLUMNS - 1 : target);
    end else if (ch == tcce_pkg::CH_NEWLINE) begin
      col = '0;
      if (move_down()) cmd = tcce_pkg::CMD_SCROLL;
    end else if (ch == tcce_pkg::CH_FORM_FEED) begin
      cmd = tcce_pkg::CMD_CLEAR;
      row = '0;
      col = '0;
    end else if (ch == tcce_pkg::CH_RETURN) begin
      col = '0;
    end else if (ch >= tcce_pkg::PRINT_LO && ch <= tcce_pkg::PRINT_HI) begin
      cmd        = tcce_pkg::CMD_WRITE;
      addr       = int'(row) * COLUMNS + int'(col);
      glyph_word = int'({bg_colour, fg_colour, ch});
      if (int'(col) + 1 >= COLUMNS) begin
        col = '0;
        wrap_scroll = move_down();
      end else begin
        col = col + 7'd1;
      end
    end
    curs = int'(row) * COLUMNS + int'(col);
    op.command = cmd;
    op.address = addr[tcce_pkg::POS_W-1:0];
    op.word    = glyph_word[tcce_pkg::WORD_W-1:0];
    op.cursor  = curs[tcce_pkg::POS_W-1:0];
    op.last    = !wrap_scroll;
    ops_due.push_back(op);
    // wrap off the bottom row adds the scroll as a second word
    if (wrap_scroll) begin
      op.command = tcce_pkg::CMD_SCROLL;
      op.address = '0;
      op.word    = '0;
      op.last    = 1'b1;
      ops_due.push_back(op);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track reset, accepted bytes, register writes and result words
  always @(posedge clk) begin : track
    screen_op_t want;
    if (!rst_n) begin
      fg_colour      = tcce_pkg::TEXT_COLOUR_RST;
      bg_colour      = tcce_pkg::BACK_COLOUR_RST;
      row            = '0;
      col            = '0;
      mismatch_count = 0;
      ops_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (ops_due.size() == 0) begin
          $display("%0t: unexpected word: expected none actual command %0d cursor %0d",
                   $time, out_command, out_cursor_position);
          mismatch_count++;
        end else begin
          want = ops_due.pop_front();
          compare_field("command", 32'(want.command), 32'(out_command));
          compare_field("cell_address", 32'(want.address), 32'(out_cell_address));
          compare_field("cell_word", 32'(want.word), 32'(out_cell_word));
          compare_field("cursor_position", 32'(want.cursor), 32'(out_cursor_position));
          compare_field("last", 32'(want.last), 32'(out_last));
        end
      end
      // a byte taken at this edge still sees the old colours
      if (in_valid && in_ready) predict_char(in_char_code);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tcce_pkg::REG_TEXT_COLOUR)
          fg_colour = cfg_data[tcce_pkg::FG_W-1:0];
        else if (cfg_index == tcce_pkg::REG_BACK_COLOUR)
          bg_colour = cfg_data[tcce_pkg::BG_W-1:0];
      end
    end
    pending_words <= ops_due.size();
  end

endmodule

### dv/tb_text_console_cursor_engine_top.sv
module tb_text_console_cursor_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 8;
  localparam int PHASE_CHARS = 90;
  localparam int QUIET_LIMIT = 1000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [tcce_pkg::CHAR_W-1:0]     in_char_code;
  logic                            out_valid;
  logic                            out_ready;
  tcce_pkg::cmd_t                  out_command;
  logic [tcce_pkg::POS_W-1:0]      out_cell_address;
  logic [tcce_pkg::WORD_W-1:0]     out_cell_word;
  logic [tcce_pkg::POS_W-1:0]      out_cursor_position;
  logic                            out_last;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              mismatch_count;
  int                              pending_words;

  // Idling switches and the long receiver hold-off
  logic tx_idle     = 1'b1;
  logic rx_idle     = 1'b1;
  int   rx_hold_len = 0;
  int   quiet_cycles = 0;

  // Printable extremes, unhandled bytes, and each control byte
  logic [tcce_pkg::CHAR_W-1:0] opening_chars[$] = '{
    8'h41, tcce_pkg::PRINT_LO, tcce_pkg::PRINT_HI, 8'h1F, 8'h7F, 8'h00, 8'hFF, 8'h80,
    tcce_pkg::CH_BACKSPACE, tcce_pkg::CH_RETURN, tcce_pkg::CH_BACKSPACE,
    tcce_pkg::CH_TAB, tcce_pkg::CH_TAB, tcce_pkg::CH_NEWLINE,
    8'h61, 8'h0B, 8'h0E, tcce_pkg::CH_FORM_FEED, tcce_pkg::CH_RETURN, 8'h7A
  };

  text_console_cursor_engine_top uut (.*);

  text_console_cursor_engine_check cursor_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_text_console_cursor_engine_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random gaps per word, plus one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      gap = rx_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one byte after a random gap; valid stays high on return
  task automatic send_char(input logic [tcce_pkg::CHAR_W-1:0] ch);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input int len);
    logic [tcce_pkg::CHAR_W-1:0] ch;
    repeat (len) begin
      ch = 8'($urandom_range(tcce_pkg::PRINT_LO, tcce_pkg::PRINT_HI));
      send_char(ch);
    end
  endtask

  // Drop valid and hold until every predicted word has come out
  task automatic drain_screen_ops();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic write_reg(input logic [tcce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcce_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One console phrase: mostly text lines, some cursor moves, some noise
  task automatic send_phrase(output int count);
    int kind;
    int len;
    logic [tcce_pkg::CHAR_W-1:0] noise;
    kind  = $urandom_range(0, 99);
    count = 0;
    if (kind < 50) begin
      len = $urandom_range(1, 12);
      send_text(len);
      count = len;
      case ($urandom_range(0, 3))
        0: begin
          send_char(tcce_pkg::CH_NEWLINE);
          count++;
        end
        1: begin
          send_char(tcce_pkg::CH_RETURN);
          send_char(tcce_pkg::CH_NEWLINE);
          count += 2;
        end
        2: begin
          send_char(tcce_pkg::CH_TAB);
          count++;
        end
        default: ;
      endcase
    end else if (kind < 56) begin
      // long line: can wrap, and scrolls once the cursor sits on the bottom row
      len = $urandom_range(60, 170);
      send_text(len);
      count = len;
    end else if (kind < 66) begin
      len = $urandom_range(1, 4);
      repeat (len) send_char(tcce_pkg::CH_TAB);
      count = len;
    end else if (kind < 74) begin
      len = $urandom_range(1, 5);
      repeat (len) send_char(tcce_pkg::CH_BACKSPACE);
      count = len;
    end else if (kind < 76) begin
      send_char(tcce_pkg::CH_FORM_FEED);
      count = 1;
    end else if (kind < 88) begin
      len = $urandom_range(1, 6);
      repeat (len) send_char(tcce_pkg::CH_NEWLINE);
      count = len;
    end else begin
      noise = 8'($urandom_range(0, 255));
      send_char(noise);
      count = 1;
    end
  endtask

  // Stimulus: reset, opening bytes, then phases under changing colours
  initial begin
    int  sent;
    int  n;
    logic pause_done;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    pause_done   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_chars[i]) send_char(opening_chars[i]);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_screen_ops();
        case (p)
          1: begin
            write_reg(tcce_pkg::REG_TEXT_COLOUR, 4'h0);
            write_reg(tcce_pkg::REG_BACK_COLOUR, 4'h0);
          end
          2: begin
            write_reg(tcce_pkg::REG_TEXT_COLOUR, 4'hF);
            write_reg(tcce_pkg::REG_BACK_COLOUR, 4'hF);
            write_reg(8'hFF, 4'h0);
          end
          default: begin
            write_reg(tcce_pkg::REG_TEXT_COLOUR, 4'($urandom_range(0, 15)));
            write_reg(tcce_pkg::REG_BACK_COLOUR, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 1))
              write_reg(8'($urandom_range(2, 255)), 4'($urandom_range(0, 15)));
          end
        endcase
      end
      tx_idle = (p % 3 != 1);
      rx_idle = (p % 4 != 2);
      if (p == 3) rx_hold_len = 60;
      sent = 0;
      while (sent < PHASE_CHARS) begin
        if (p == 5 && sent >= 60 && !pause_done) begin
          drain_screen_ops();
          pause_done = 1'b1;
        end
        send_phrase(n);
        sent += n;
      end
    end

    drain_screen_ops();
    repeat (4) @(posedge clk);
    if (pending_words != 0)
      $display("%0t: %0d result words never arrived", $time, pending_words);
    if (mismatch_count == 0 && pending_words == 0)
      $display("tb_text_console_cursor_engine_top: PASS");
    else
      $display("tb_text_console_cursor_engine_top: FAIL");
    $finish;
  end

endmodule
